@@ sv/ttb_pkg.sv @@
// Package for the triangle tangent/bitangent unit.
// Holds the constants, payload types, the queued job type, the sequencer states and a helper.
// No dependencies.
package ttb_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int MUL_STEPS       = 14;
    localparam int DIV_STEPS       = 80;
    localparam int NUM_ACC         = 7;
    localparam int NUM_LANES       = 6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_in;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic signed [31:0] bitangent_x;
        logic signed [31:0] bitangent_y;
        logic signed [31:0] bitangent_z;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic signed [31:0] e1_x;
        logic signed [31:0] e1_y;
        logic signed [31:0] e1_z;
        logic signed [31:0] e2_x;
        logic signed [31:0] e2_y;
        logic signed [31:0] e2_z;
        logic signed [31:0] d1_u;
        logic signed [31:0] d1_v;
        logic signed [31:0] d2_u;
        logic signed [31:0] d2_v;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    // Subtract with saturation to signed 32 bits
    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (d < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return d[31:0];
    endfunction

endpackage

@@ sv/triangle_tangent_bitangent_unit.sv @@
// Triangle tangent/bitangent unit. Corners (position and UV, signed Q16.16)
// stream in; every third corner closes a triangle and yields one result with
// saturated Q16.16 tangent and bitangent and a degenerate flag (zero UV
// determinant, zero vectors). The front end takes one corner per cycle unless
// the queue is full, and hands each triangle to a job queue; the back end
// works on one triangle at a time, first on its single 32x32 multiplier and
// then in the restoring divider lanes (one quotient bit per cycle), plus
// set-up and hand-off. With the default depth the queue lets the next two
// triangles' corners be taken while one is in the back end.
module triangle_tangent_bitangent_unit #(
    parameter int QUEUE_DEPTH = ttb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ttb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ttb_pkg::t_out o_out_data
);
    import ttb_pkg::*;

    logic w_push;
    logic w_full;
    logic w_qvalid;
    logic w_pop;
    t_job w_fjob;
    t_job w_qjob;

    ttb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .o_push  (w_push),
        .o_job   (w_fjob),
        .i_full  (w_full)
    );

    ttb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .o_job   (w_qjob),
        .i_pop   (w_pop)
    );

    ttb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qvalid),
        .i_job       (w_qjob),
        .o_pop       (w_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

@@ sv/ttb_front.sv @@
// Front end: collects the corners of a triangle and forms edges and UV deltas.
// Depends on ttb_pkg.
module ttb_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  ttb_pkg::t_in  i_data,
    output logic          o_push,
    output ttb_pkg::t_job o_job,
    input  logic          i_full
);
    import ttb_pkg::*;

    logic [1:0] r_cnt;
    t_in        r_c0;
    t_in        r_c1;
    logic       w_acc;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;
    assign o_push  = w_acc && (r_cnt == 2'd2);

    // Count corners, restart after the third
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (w_acc) begin
            r_cnt <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
        end
    end

    // Hold the first two corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
        end else if (w_acc) begin
            if (r_cnt == 2'd0) begin
                r_c0 <= i_data;
            end
            if (r_cnt == 2'd1) begin
                r_c1 <= i_data;
            end
        end
    end

    // Form saturated edges and deltas
    always_comb begin
        o_job.e1_x = sat_sub(r_c1.pos_x, r_c0.pos_x);
        o_job.e1_y = sat_sub(r_c1.pos_y, r_c0.pos_y);
        o_job.e1_z = sat_sub(r_c1.pos_z, r_c0.pos_z);
        o_job.e2_x = sat_sub(i_data.pos_x, r_c0.pos_x);
        o_job.e2_y = sat_sub(i_data.pos_y, r_c0.pos_y);
        o_job.e2_z = sat_sub(i_data.pos_z, r_c0.pos_z);
        o_job.d1_u = sat_sub(r_c1.tex_u, r_c0.tex_u);
        o_job.d1_v = sat_sub(r_c1.tex_v, r_c0.tex_v);
        o_job.d2_u = sat_sub(i_data.tex_u, r_c0.tex_u);
        o_job.d2_v = sat_sub(i_data.tex_v, r_c0.tex_v);
    end

endmodule

@@ sv/ttb_queue.sv @@
// Short queue of triangle jobs between the front and back ends.
// Depends on ttb_pkg.
module ttb_queue #(
    parameter int DEPTH = ttb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttb_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output ttb_pkg::t_job o_job,
    input  logic          i_pop
);
    import ttb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store a job
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ sv/ttb_back.sv @@
// Back end: one shared multiplier forms the determinant and numerators,
// six restoring division lanes form the vectors. Depends on ttb_pkg.
module ttb_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  ttb_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output ttb_pkg::t_out o_data
);
    import ttb_pkg::*;

    t_state r_state;
    t_state n_state;
    t_job   r_job;

    logic [3:0]         r_k;
    logic signed [63:0] r_prod;
    logic [2:0]         r_tgt;
    logic               r_sub;
    logic               r_pv;
    logic signed [64:0] r_acc [NUM_ACC];

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic [2:0]         w_tgt;
    logic               w_sub;

    logic [6:0]  r_dc;
    logic [63:0] r_det;
    logic        r_degen;
    logic [79:0] r_dvd [NUM_LANES];
    logic [63:0] r_rem [NUM_LANES];
    logic [32:0] r_q   [NUM_LANES];
    logic        r_big [NUM_LANES];
    logic        r_neg [NUM_LANES];

    logic               w_load;
    logic signed [31:0] w_res [NUM_LANES];
    t_out               r_out;
    logic               r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_job_valid) n_state = ST_MUL;
            ST_MUL:  if (r_k == 4'(MUL_STEPS)) n_state = ST_PREP;
            ST_PREP: n_state = (r_acc[0] == '0) ? ST_DONE : ST_DIV;
            ST_DIV:  if (r_dc == 7'(DIV_STEPS - 1)) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = i_job_valid;
            ST_DONE: w_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Select multiplier operands and target accumulator
    always_comb begin
        w_a = r_job.d1_u; w_b = r_job.d2_v; w_tgt = 3'd0; w_sub = 1'b0;
        case (r_k)
            4'd1:  begin w_a = r_job.d2_u; w_b = r_job.d1_v; w_tgt = 3'd0; w_sub = 1'b1; end
            4'd2:  begin w_a = r_job.d2_v; w_b = r_job.e1_x; w_tgt = 3'd1; w_sub = 1'b0; end
            4'd3:  begin w_a = r_job.d1_v; w_b = r_job.e2_x; w_tgt = 3'd1; w_sub = 1'b1; end
            4'd4:  begin w_a = r_job.d2_v; w_b = r_job.e1_y; w_tgt = 3'd2; w_sub = 1'b0; end
            4'd5:  begin w_a = r_job.d1_v; w_b = r_job.e2_y; w_tgt = 3'd2; w_sub = 1'b1; end
            4'd6:  begin w_a = r_job.d2_v; w_b = r_job.e1_z; w_tgt = 3'd3; w_sub = 1'b0; end
            4'd7:  begin w_a = r_job.d1_v; w_b = r_job.e2_z; w_tgt = 3'd3; w_sub = 1'b1; end
            4'd8:  begin w_a = r_job.d1_u; w_b = r_job.e2_x; w_tgt = 3'd4; w_sub = 1'b0; end
            4'd9:  begin w_a = r_job.d2_u; w_b = r_job.e1_x; w_tgt = 3'd4; w_sub = 1'b1; end
            4'd10: begin w_a = r_job.d1_u; w_b = r_job.e2_y; w_tgt = 3'd5; w_sub = 1'b0; end
            4'd11: begin w_a = r_job.d2_u; w_b = r_job.e1_y; w_tgt = 3'd5; w_sub = 1'b1; end
            4'd12: begin w_a = r_job.d1_u; w_b = r_job.e2_z; w_tgt = 3'd6; w_sub = 1'b0; end
            4'd13: begin w_a = r_job.d2_u; w_b = r_job.e1_z; w_tgt = 3'd6; w_sub = 1'b1; end
            default: ;
        endcase
    end

    // Take a job, run the multiply-accumulate sequence
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
            r_k   <= '0;
            r_pv  <= 1'b0;
            for (int j = 0; j < NUM_ACC; j++) begin
                r_acc[j] <= '0;
            end
        end else if (r_state == ST_MUL) begin
            r_k    <= r_k + 4'd1;
            r_pv   <= (r_k != 4'(MUL_STEPS));
            r_prod <= w_a * w_b;
            r_tgt  <= w_tgt;
            r_sub  <= w_sub;
            if (r_pv) begin
                r_acc[r_tgt] <= r_sub ? r_acc[r_tgt] - 65'(r_prod)
                                      : r_acc[r_tgt] + 65'(r_prod);
            end
        end
    end

    // Load the division lanes, then shift one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            logic signed [64:0] m;
            r_dc    <= '0;
            r_degen <= (r_acc[0] == '0);
            m        = r_acc[0][64] ? -r_acc[0] : r_acc[0];
            r_det   <= m[63:0];
            for (int j = 0; j < NUM_LANES; j++) begin
                m         = r_acc[j + 1][64] ? -r_acc[j + 1] : r_acc[j + 1];
                r_dvd[j] <= {m[63:0], 16'h0000};
                r_rem[j] <= '0;
                r_q[j]   <= '0;
                r_big[j] <= 1'b0;
                r_neg[j] <= r_acc[j + 1][64] ^ r_acc[0][64];
            end
        end else if (r_state == ST_DIV) begin
            logic [64:0] rs;
            logic [64:0] df;
            r_dc <= r_dc + 7'd1;
            for (int j = 0; j < NUM_LANES; j++) begin
                rs        = {r_rem[j], r_dvd[j][79]};
                df        = rs - {1'b0, r_det};
                r_dvd[j] <= {r_dvd[j][78:0], 1'b0};
                r_big[j] <= r_big[j] | r_q[j][32];
                if (!df[64]) begin
                    r_rem[j] <= df[63:0];
                    r_q[j]   <= {r_q[j][31:0], 1'b1};
                end else begin
                    r_rem[j] <= rs[63:0];
                    r_q[j]   <= {r_q[j][31:0], 1'b0};
                end
            end
        end
    end

    // Saturate each quotient to signed 32 bits, or give zero when degenerate
    always_comb begin
        for (int j = 0; j < NUM_LANES; j++) begin
            if (r_degen) begin
                w_res[j] = '0;
            end else if (r_neg[j]) begin
                if (r_big[j] || r_q[j] > 33'h080000000) begin
                    w_res[j] = 32'sh80000000;
                end else begin
                    w_res[j] = -$signed(r_q[j][31:0]);
                end
            end else if (r_big[j] || r_q[j] > 33'h07FFFFFFF) begin
                w_res[j] = 32'sh7FFFFFFF;
            end else begin
                w_res[j] = $signed(r_q[j][31:0]);
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.tangent_x   <= w_res[0];
            r_out.tangent_y   <= w_res[1];
            r_out.tangent_z   <= w_res[2];
            r_out.bitangent_x <= w_res[3];
            r_out.bitangent_y <= w_res[4];
            r_out.bitangent_z <= w_res[5];
            r_out.degenerate  <= r_degen;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
